/* rtl/imm_pkg.sv */
package imm_pkg;

	localparam int VAL_W  = 8;
	localparam int PROD_W = 16;
	localparam int ACC_W  = 22;
	localparam int CFG_W  = 7;

	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_READ_C = 2'd2;

	localparam logic [1:0] CFG_ROWS_M  = 2'd0;
	localparam logic [1:0] CFG_INNER_K = 2'd1;
	localparam logic [1:0] CFG_COLS_N  = 2'd2;

	localparam logic [4:0] ROWS_M_RST  = 5'd16;
	localparam logic [6:0] INNER_K_RST = 7'd64;
	localparam logic [4:0] COLS_N_RST  = 5'd16;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctrl_t;

endpackage

/* rtl/imm_in_if.sv */
interface imm_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [5:0]        row;
	logic [5:0]        col;
	logic signed [7:0] value;

	modport source (output valid, func, row, col, value, input ready);
	modport sink   (input valid, func, row, col, value, output ready);
endinterface

/* rtl/imm_out_if.sv */
interface imm_out_if;
	logic               valid;
	logic               ready;
	logic signed [21:0] product_value;
	logic               status;

	modport source (output valid, product_value, status, input ready);
	modport sink   (input valid, product_value, status, output ready);
endinterface

/* rtl/imm_ram.sv */
module imm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/imm_mac.sv */
module imm_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  imm_pkg::mac_ctrl_t                   ctrl,
	input  logic signed [imm_pkg::VAL_W-1:0]     a,
	input  logic signed [imm_pkg::VAL_W-1:0]     b,
	output logic                                 busy,
	output logic signed [imm_pkg::ACC_W-1:0]     acc
);

	logic signed [imm_pkg::PROD_W-1:0] prod_s1;
	logic                              pv_s1;
	logic signed [imm_pkg::ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			pv_s1 <= ctrl.valid & ~ctrl.clear;
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (pv_s1) begin
				acc_q <= acc_q + imm_pkg::ACC_W'(prod_s1);
			end
		end
	end

	assign busy = pv_s1;
	assign acc  = acc_q;

endmodule

/* rtl/int8_matrix_multiply.sv */
// channel | dir | payload                              | accepted when
// in_ch   | in  | func[1:0] row[5:0] col[5:0] value[7:0] | valid & ready
// out_ch  | out | product_value[21:0] status           | valid & ready
// cfg     | in  | cfg_index[1:0] cfg_data[6:0]          | cfg_write
// Loads are accepted one per cycle, back to back, while no read runs. A C read streams
// min(inner_k, MAX_INNER) A/B element pairs, one per cycle, through the single MAC,
// via the RAM read and product registers; out-of-range reads return zero with status set.
// in_ch.ready is low while a read runs or while its result waits for a full output register.
// Reset restores the size registers; matrix contents are undefined until loaded.
module int8_matrix_multiply #(
	parameter int MAX_ROWS  = 16,
	parameter int MAX_INNER = 64,
	parameter int MAX_COLS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	imm_in_if.sink                    in_ch,
	imm_out_if.source                 out_ch,
	input  logic                      cfg_write,
	input  logic [1:0]                cfg_index,
	input  logic [imm_pkg::CFG_W-1:0] cfg_data
);

	localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
	localparam int B_DEPTH = MAX_INNER * MAX_COLS;
	localparam int A_AW    = A_DEPTH > 1 ? $clog2(A_DEPTH) : 1;
	localparam int B_AW    = B_DEPTH > 1 ? $clog2(B_DEPTH) : 1;
	localparam int RW      = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int CW      = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int KW      = MAX_INNER > 1 ? $clog2(MAX_INNER) : 1;
	localparam int KCW     = $clog2(MAX_INNER + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	logic [4:0] rows_m_q;
	logic [6:0] inner_k_q;
	logic [4:0] cols_n_q;
	logic [6:0] em, ek, en;

	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [KCW-1:0] k_q;
	logic           err_q;
	logic           rd_s1;

	logic           accept;
	logic           row_in_m, row_in_k, col_in_k, col_in_n;
	logic           a_we, b_we;
	logic [A_AW-1:0] a_waddr, a_raddr;
	logic [B_AW-1:0] b_waddr, b_raddr;
	logic [imm_pkg::VAL_W-1:0] a_rdata, b_rdata;
	logic           issue;
	logic           mac_busy;
	logic signed [imm_pkg::ACC_W-1:0] acc;
	imm_pkg::mac_ctrl_t mac_ctrl;
	logic           start_read;
	logic           load_out;

	logic                             out_valid_q;
	logic signed [imm_pkg::ACC_W-1:0] out_value_q;
	logic                             out_status_q;

	always_comb begin
		em = ({2'b00, rows_m_q} > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : {2'b00, rows_m_q};
		ek = (inner_k_q > 7'(MAX_INNER)) ? 7'(MAX_INNER) : inner_k_q;
		en = ({2'b00, cols_n_q} > 7'(MAX_COLS)) ? 7'(MAX_COLS) : {2'b00, cols_n_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= imm_pkg::ROWS_M_RST;
			inner_k_q <= imm_pkg::INNER_K_RST;
			cols_n_q  <= imm_pkg::COLS_N_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				imm_pkg::CFG_ROWS_M:  rows_m_q  <= cfg_data[4:0];
				imm_pkg::CFG_INNER_K: inner_k_q <= cfg_data;
				imm_pkg::CFG_COLS_N:  cols_n_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid & in_ch.ready;

	assign row_in_m = {1'b0, in_ch.row} < em;
	assign row_in_k = {1'b0, in_ch.row} < ek;
	assign col_in_k = {1'b0, in_ch.col} < ek;
	assign col_in_n = {1'b0, in_ch.col} < en;

	assign a_we = accept & (in_ch.func == imm_pkg::FUNC_LOAD_A) & row_in_m & col_in_k;
	assign b_we = accept & (in_ch.func == imm_pkg::FUNC_LOAD_B) & row_in_k & col_in_n;
	assign start_read = accept & (in_ch.func == imm_pkg::FUNC_READ_C);

	assign a_waddr = A_AW'(int'(in_ch.row) * MAX_INNER + int'(in_ch.col));
	assign b_waddr = B_AW'(int'(in_ch.row) * MAX_COLS + int'(in_ch.col));
	assign a_raddr = A_AW'(int'(row_q) * MAX_INNER + int'(k_q[KW-1:0]));
	assign b_raddr = B_AW'(int'(k_q[KW-1:0]) * MAX_COLS + int'(col_q));

	assign issue = (state_q == S_RUN) & (k_q < KCW'(ek));

	imm_ram #(.WIDTH(imm_pkg::VAL_W), .DEPTH(A_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (in_ch.value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	imm_ram #(.WIDTH(imm_pkg::VAL_W), .DEPTH(B_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (in_ch.value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	assign mac_ctrl.clear = start_read;
	assign mac_ctrl.valid = rd_s1;

	imm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (signed'(a_rdata)),
		.b      (signed'(b_rdata)),
		.busy   (mac_busy),
		.acc    (acc)
	);

	assign load_out = (state_q == S_DONE) & (~out_valid_q | out_ch.ready);

	always_ff @(posedge clk) begin
		if (start_read) begin
			row_q <= in_ch.row[RW-1:0];
			col_q <= in_ch.col[CW-1:0];
		end
		if (load_out) begin
			out_value_q  <= err_q ? '0 : acc;
			out_status_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			err_q       <= 1'b0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (issue) begin
				k_q <= k_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start_read) begin
						k_q   <= '0;
						err_q <= ~(row_in_m & col_in_n);
						state_q <= (row_in_m & col_in_n) ? S_RUN : S_DONE;
					end
				end
				S_RUN: begin
					if (!issue && !rd_s1 && !mac_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.product_value = out_value_q;
	assign out_ch.status        = out_status_q;

`ifndef SYNTHESIS
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(a_we || b_we) |-> state_q == S_IDLE)
		else $error("matrix write outside idle");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> k_q <= KCW'(ek))
		else $error("inner index ran past inner size");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> !rd_s1 && !mac_busy)
		else $error("result taken before accumulation drained");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && err_q |=> out_ch.product_value == '0 && out_ch.status)
		else $error("out-of-range read gave nonzero value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q)
		else $error("pending result dropped");
`endif

endmodule
